### rtl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types, constants and the sigmoid table of the perceptron trainer.
// ----------------------------------------------------------------------------
package mbt_pkg;

    // Network shape and weight store layout.
    localparam int INPUT_COUNT  = 2;
    localparam int HIDDEN_COUNT = 5;
    localparam int OUTPUT_COUNT = 2;
    localparam int OFS_HB       = INPUT_COUNT * HIDDEN_COUNT;
    localparam int OFS_HO       = OFS_HB + HIDDEN_COUNT;
    localparam int OFS_OB       = OFS_HO + HIDDEN_COUNT * OUTPUT_COUNT;
    localparam int STORE_SIZE   = OFS_OB + OUTPUT_COUNT;
    localparam int ADDR_W       = $clog2(STORE_SIZE);
    localparam int MASK_BITS    = 5;

    // Field and datapath widths.
    localparam int W_W     = 20;
    localparam int X_W     = 16;
    localparam int ACT_W   = 13;
    localparam int LR_W    = 16;
    localparam int ACC_W   = 40;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ONE_Q12 = 4096;

    // Item kinds.
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_INFER = 2'd1;
    localparam logic [1:0] KIND_TRAIN = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FROZEN_MASK   = 2'd1;
    localparam logic [LR_W-1:0]      LR_RESET          = 16'd8520;

    // Sigmoid table.
    localparam int SIG_SIZE  = 256;
    localparam int SIG_IDX_W = $clog2(SIG_SIZE);
    localparam longint unsigned INV_E_Q30 = 64'd395007542;

    typedef logic [ACT_W-1:0] sig_table_t [SIG_SIZE];

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_RD,
        ST_F_MUL,
        ST_F_ACC,
        ST_F_ACT,
        ST_O_Y,
        ST_O_D1,
        ST_O_D2,
        ST_O_D3,
        ST_H_RD,
        ST_H_MUL,
        ST_H_ACC,
        ST_H_DER,
        ST_H_D1,
        ST_H_D2,
        ST_U_RD,
        ST_U_M2,
        ST_U_WR,
        ST_FIN
    } state_t;

    // Unsigned quotient by restoring shift and subtract; used only while the
    // table is built at elaboration.
    function automatic longint unsigned udiv64(longint unsigned num,
                                               longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Each entry is the rounded sigmoid at the center of its segment of [-8, 8).
    function automatic sig_table_t build_sig_table();
        sig_table_t         tab;
        longint             z;
        longint             sum;
        longint unsigned    az;
        longint unsigned    a;
        longint unsigned    n;
        longint unsigned    f;
        longint unsigned    mag;
        longint unsigned    r;
        longint unsigned    den;
        longint unsigned    sp;
        longint unsigned    k;
        longint unsigned    m;
        for (int i = 0; i < SIG_SIZE; i++)
        begin
            z   = -32768 + longint'(udiv64(64'((2 * longint'(i) + 1) * 65536),
                                           64'(2 * SIG_SIZE)));
            az  = longint'(z < 0 ? -z : z);
            a   = az << 18;
            n   = a >> 30;
            f   = a & ((64'd1 << 30) - 1);
            mag = 64'd1 << 30;
            sum = longint'(64'd1 << 30);
            for (k = 1; k <= 20; k++)
            begin
                mag = udiv64((mag * f) >> 30, k);
                if (k[0]) sum = sum - longint'(mag);
                else sum = sum + longint'(mag);
            end
            r = (sum > 0) ? longint'(sum) : 64'd0;
            for (m = 0; m < n && m < 16; m++)
            begin
                r = (r * INV_E_Q30 + (64'd1 << 29)) >> 30;
            end
            den = (64'd1 << 30) + r;
            sp  = udiv64((64'd1 << 42) + (den >> 1), den);
            tab[i] = (z < 0) ? ACT_W'(ONE_Q12 - longint'(sp)) : ACT_W'(sp);
        end
        return tab;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

### rtl/mbt_if.sv
// ----------------------------------------------------------------------------
// mbt channels
// Valid/ready channels of the trainer: sample items, result items, config.
// ----------------------------------------------------------------------------
interface mbt_sample_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] x_first;
    logic signed [15:0] x_second;
    logic [12:0]        target_first;
    logic [12:0]        target_second;
    logic [4:0]         weight_index;
    logic signed [19:0] weight_value;

    modport source (output valid, kind, x_first, x_second, target_first,
                    target_second, weight_index, weight_value, input ready);
    modport sink   (input valid, kind, x_first, x_second, target_first,
                    target_second, weight_index, weight_value, output ready);
endinterface

interface mbt_result_if;
    logic        valid;
    logic        ready;
    logic [12:0] y_first;
    logic [12:0] y_second;
    logic [12:0] loss;

    modport source (output valid, y_first, y_second, loss, input ready);
    modport sink   (input valid, y_first, y_second, loss, output ready);
endinterface

interface mbt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/mlp_backprop_trainer_core.sv
// ----------------------------------------------------------------------------
// mlp_backprop_trainer_core
// Two-layer sigmoid perceptron trained by stochastic gradient descent.
// ----------------------------------------------------------------------------
// Usage: a sample item either loads one weight (kind 0), runs inference
// (kind 1 or 3) or runs one training step (kind 2). Every item gives one
// result item with the outputs and, for training, half the summed squared
// error. The cfg channel writes the learning rate and the frozen mask; it is
// always ready; the user must write it only while the block is idle, which
// the block does not enforce. The weights live in a RAM with one read and
// one write port; a single shared multiplier visits each weight at most once
// per pass. A load goes straight to the result; inference runs the forward
// pass and training adds the output, hidden and update passes, where a
// frozen hidden neuron skips its error terms and updates. The next item is
// taken from the cycle after the result is registered; one item is in work
// at a time. A finished result waits in the output register, so the next
// item is taken while the receiver stalls; that item holds at its end until
// the register frees up. Reset clears all weights to zero (per-entry valid
// bits, no clearing pass), the learning rate to 8520 and the mask to zero.
// ----------------------------------------------------------------------------
module mlp_backprop_trainer_core
    import mbt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mbt_sample_if.sink    sample,
    mbt_result_if.source  result,
    mbt_cfg_if.sink       cfg
);

    // Control and configuration.
    state_t                  state_reg, state_next;
    logic                    train_reg;
    logic                    load_reg;
    logic [LR_W-1:0]         lr_reg;
    logic [MASK_BITS-1:0]    mask_reg;
    logic [STORE_SIZE-1:0]   valid_reg;
    logic                    rvalid_reg;
    logic [2:0]              n_reg;
    logic [2:0]              m_reg;
    logic [2:0]              j_reg;
    logic [ADDR_W-1:0]       u_reg;

    // Datapath registers.
    logic signed [X_W-1:0]     x_reg  [INPUT_COUNT];
    logic [ACT_W-1:0]          t_reg  [OUTPUT_COUNT];
    logic [ACT_W-1:0]          h_reg  [HIDDEN_COUNT];
    logic [ACT_W-1:0]          y_reg  [OUTPUT_COUNT];
    logic signed [11:0]        d_reg  [OUTPUT_COUNT];
    logic signed [17:0]        hd_reg [HIDDEN_COUNT];
    logic [10:0]               der_reg;
    logic signed [32:0]        err_reg;
    logic [25:0]               sq_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [MUL_P_W-1:0] p_reg;

    // Output register.
    logic                    out_valid_reg;
    logic [ACT_W-1:0]        out_y1_reg;
    logic [ACT_W-1:0]        out_y2_reg;
    logic [ACT_W-1:0]        out_loss_reg;

    // RAM and multiplier signals.
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [W_W-1:0]            ram_wdata;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [W_W-1:0]            ram_rdata;
    logic signed [W_W-1:0]     wv;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      p_load;

    // Helper values.
    logic                      sample_acc;
    logic                      out_free;
    logic                      is_hidden;
    logic [2:0]                ko;
    logic [2:0]                m_dec;
    logic                      last_term;
    logic signed [ACC_W-1:0]   z_full;
    logic signed [X_W-1:0]     z_clamp;
    logic [ACT_W-1:0]          act;
    logic signed [13:0]        e_val;
    logic signed [20:0]        err_sh;
    logic                      grp_ih;
    logic                      grp_hb;
    logic                      grp_ho;
    logic                      grp_ob;
    logic                      u_skip;
    logic signed [29:0]        upd_delta;
    logic signed [29:0]        upd_sum;
    logic signed [W_W-1:0]     upd_sat;
    logic [13:0]               loss_full;
    logic [ACT_W-1:0]          loss_val;

    mbt_ram #(
        .WIDTH (W_W),
        .DEPTH (STORE_SIZE)
    ) u_weights (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes.
    assign sample.ready = (state_reg == ST_IDLE);
    assign sample_acc   = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;
    assign out_free     = !out_valid_reg || result.ready;

    assign result.valid    = out_valid_reg;
    assign result.y_first  = out_y1_reg;
    assign result.y_second = out_y2_reg;
    assign result.loss     = out_loss_reg;

    // Never-written entries read as zero.
    assign wv = rvalid_reg ? $signed(ram_rdata) : '0;

    // Forward-pass decode: neuron n is hidden below HIDDEN_COUNT.
    assign is_hidden = (n_reg < 3'(HIDDEN_COUNT));
    assign ko        = n_reg - 3'(HIDDEN_COUNT);
    assign m_dec     = m_reg - 3'd1;
    assign last_term = is_hidden ? (m_reg == 3'(INPUT_COUNT))
                                 : (m_reg == 3'(HIDDEN_COUNT));

    // Activation: round, clamp to the table range, look up.
    assign z_full = (acc_reg + ACC_W'(2048)) >>> 12;
    always_comb
    begin
        if (z_full > ACC_W'(32767))
        begin
            z_clamp = 16'sd32767;
        end
        else if (z_full < -ACC_W'(32768))
        begin
            z_clamp = -16'sd32768;
        end
        else
        begin
            z_clamp = z_full[X_W-1:0];
        end
    end
    assign act = SIG_TABLE[{~z_clamp[X_W-1], z_clamp[X_W-2 -: SIG_IDX_W-1]}];

    // Output error and back-propagated error, rounded.
    assign e_val  = $signed({1'b0, t_reg[j_reg[0]]}) - $signed({1'b0, y_reg[j_reg[0]]});
    assign err_sh = 21'((err_reg + 33'sd2048) >>> 12);

    // Update pass groups by address.
    assign grp_ih = (u_reg < ADDR_W'(OFS_HB));
    assign grp_hb = !grp_ih && (u_reg < ADDR_W'(OFS_HO));
    assign grp_ho = !grp_ih && !grp_hb && (u_reg < ADDR_W'(OFS_OB));
    assign grp_ob = !grp_ih && !grp_hb && !grp_ho;
    assign u_skip = !grp_ob && mask_reg[j_reg];

    // Weight update: rounded scaled step added with saturation.
    assign upd_delta = (grp_ih || grp_ho) ? 30'((p_reg + (MUL_P_W'(1) <<< 27)) >>> 28)
                                          : 30'((p_reg + (MUL_P_W'(1) <<< 15)) >>> 16);
    assign upd_sum   = 30'(wv) + upd_delta;
    always_comb
    begin
        if (upd_sum > 30'sd524287)
        begin
            upd_sat = 20'sd524287;
        end
        else if (upd_sum < -30'sd524288)
        begin
            upd_sat = -20'sd524288;
        end
        else
        begin
            upd_sat = upd_sum[W_W-1:0];
        end
    end

    // Loss: half the squared error sum, rounded, saturated.
    assign loss_full = 14'((27'(sq_reg) + 27'd4096) >> 13);
    assign loss_val  = (loss_full > 14'd8191) ? 13'd8191 : loss_full[ACT_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_acc)
                begin
                    state_next = (sample.kind == KIND_LOAD) ? ST_FIN : ST_F_RD;
                end
            end
            ST_F_RD:  state_next = ST_F_MUL;
            ST_F_MUL: state_next = ST_F_ACC;
            ST_F_ACC: state_next = last_term ? ST_F_ACT : ST_F_RD;
            ST_F_ACT:
            begin
                if (n_reg == 3'(HIDDEN_COUNT + OUTPUT_COUNT - 1))
                begin
                    state_next = train_reg ? ST_O_Y : ST_FIN;
                end
                else
                begin
                    state_next = ST_F_RD;
                end
            end
            ST_O_Y:  state_next = ST_O_D1;
            ST_O_D1: state_next = ST_O_D2;
            ST_O_D2: state_next = ST_O_D3;
            ST_O_D3: state_next = (j_reg == 3'(OUTPUT_COUNT - 1)) ? ST_H_RD : ST_O_Y;
            ST_H_RD:
            begin
                if (!mask_reg[j_reg])
                begin
                    state_next = ST_H_MUL;
                end
                else if (j_reg == 3'(HIDDEN_COUNT - 1))
                begin
                    state_next = ST_U_RD;
                end
            end
            ST_H_MUL: state_next = ST_H_ACC;
            ST_H_ACC: state_next = (m_reg == 3'(OUTPUT_COUNT - 1)) ? ST_H_DER : ST_H_RD;
            ST_H_DER: state_next = ST_H_D1;
            ST_H_D1:  state_next = ST_H_D2;
            ST_H_D2:  state_next = (j_reg == 3'(HIDDEN_COUNT - 1)) ? ST_U_RD : ST_H_RD;
            ST_U_RD:
            begin
                if (!u_skip)
                begin
                    state_next = ST_U_M2;
                end
                else if (u_reg == ADDR_W'(STORE_SIZE - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_U_M2: state_next = ST_U_WR;
            ST_U_WR: state_next = (u_reg == ADDR_W'(STORE_SIZE - 1)) ? ST_FIN : ST_U_RD;
            ST_FIN:  state_next = out_free ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    // RAM and multiplier controls per state.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        mul_a     = '0;
        mul_b     = '0;
        p_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_we    = sample_acc && (sample.kind == KIND_LOAD)
                            && (sample.weight_index < ADDR_W'(STORE_SIZE));
                ram_waddr = sample.weight_index;
                ram_wdata = sample.weight_value;
            end
            ST_F_RD:
            begin
                ram_re = 1'b1;
                if (is_hidden)
                begin
                    ram_raddr = (m_reg == 3'd0) ? ADDR_W'(OFS_HB) + ADDR_W'(n_reg)
                                : ADDR_W'(m_dec) * ADDR_W'(HIDDEN_COUNT) + ADDR_W'(n_reg);
                end
                else
                begin
                    ram_raddr = (m_reg == 3'd0) ? ADDR_W'(OFS_OB) + ADDR_W'(ko)
                                : ADDR_W'(OFS_HO) + ADDR_W'(m_dec) * ADDR_W'(OUTPUT_COUNT)
                                  + ADDR_W'(ko);
                end
            end
            ST_F_MUL:
            begin
                p_load = 1'b1;
                mul_b  = wv;
                if (m_reg == 3'd0)
                begin
                    mul_a = MUL_A_W'(ONE_Q12);
                end
                else if (is_hidden)
                begin
                    mul_a = MUL_A_W'(x_reg[m_dec[0]]);
                end
                else
                begin
                    mul_a = MUL_A_W'($signed({1'b0, h_reg[m_dec]}));
                end
            end
            ST_O_Y:
            begin
                p_load = 1'b1;
                mul_a  = MUL_A_W'($signed({1'b0, y_reg[j_reg[0]]}));
                mul_b  = MUL_B_W'(ONE_Q12) - MUL_B_W'($signed({1'b0, y_reg[j_reg[0]]}));
            end
            ST_O_D1:
            begin
                p_load = 1'b1;
                mul_a  = MUL_A_W'(e_val);
                mul_b  = MUL_B_W'(e_val);
            end
            ST_O_D2:
            begin
                p_load = 1'b1;
                mul_a  = MUL_A_W'(e_val);
                mul_b  = MUL_B_W'($signed({1'b0, der_reg}));
            end
            ST_H_RD:
            begin
                ram_re    = !mask_reg[j_reg];
                ram_raddr = ADDR_W'(OFS_HO) + ADDR_W'(j_reg) * ADDR_W'(OUTPUT_COUNT)
                            + ADDR_W'(m_reg);
            end
            ST_H_MUL:
            begin
                p_load = 1'b1;
                mul_a  = MUL_A_W'(d_reg[m_reg[0]]);
                mul_b  = wv;
            end
            ST_H_DER:
            begin
                p_load = 1'b1;
                mul_a  = MUL_A_W'($signed({1'b0, h_reg[j_reg]}));
                mul_b  = MUL_B_W'(ONE_Q12) - MUL_B_W'($signed({1'b0, h_reg[j_reg]}));
            end
            ST_H_D1:
            begin
                // The derivative comes straight from the product of the previous cycle.
                p_load = 1'b1;
                mul_a  = MUL_A_W'(err_sh);
                mul_b  = MUL_B_W'($signed({1'b0, p_reg[22:12]}));
            end
            ST_U_RD:
            begin
                ram_re    = !u_skip;
                ram_raddr = u_reg;
                p_load    = !u_skip;
                priority if (grp_ih)
                begin
                    mul_a = MUL_A_W'(x_reg[m_reg[0]]);
                    mul_b = MUL_B_W'(hd_reg[j_reg]);
                end
                else if (grp_hb)
                begin
                    mul_a = MUL_A_W'(hd_reg[j_reg]);
                    mul_b = MUL_B_W'($signed({1'b0, lr_reg}));
                end
                else if (grp_ho)
                begin
                    mul_a = MUL_A_W'($signed({1'b0, h_reg[j_reg]}));
                    mul_b = MUL_B_W'(d_reg[m_reg[0]]);
                end
                else
                begin
                    mul_a = MUL_A_W'(d_reg[m_reg[0]]);
                    mul_b = MUL_B_W'($signed({1'b0, lr_reg}));
                end
            end
            ST_U_M2:
            begin
                p_load = grp_ih || grp_ho;
                mul_a  = p_reg[MUL_A_W-1:0];
                mul_b  = MUL_B_W'($signed({1'b0, lr_reg}));
            end
            ST_U_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = u_reg;
                ram_wdata = upd_sat;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lr_reg        <= LR_RESET;
            mask_reg      <= '0;
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            train_reg     <= 1'b0;
            load_reg      <= 1'b0;
            n_reg         <= '0;
            m_reg         <= '0;
            j_reg         <= '0;
            u_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_LEARNING_RATE)
                begin
                    lr_reg <= cfg.data;
                end
                else if (cfg.index == REG_FROZEN_MASK)
                begin
                    mask_reg <= cfg.data[MASK_BITS-1:0];
                end
            end

            // Entry valid bits and valid flag of the last read.
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re)
            begin
                rvalid_reg <= valid_reg[ram_raddr];
            end

            // Result delivery: a new result takes precedence over a drained one.
            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Sequence counters.
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_acc)
                    begin
                        train_reg <= (sample.kind == KIND_TRAIN);
                        load_reg  <= (sample.kind == KIND_LOAD);
                        n_reg     <= '0;
                        m_reg     <= '0;
                        j_reg     <= '0;
                    end
                end
                ST_F_ACC:
                begin
                    m_reg <= last_term ? 3'd0 : m_reg + 3'd1;
                end
                ST_F_ACT:
                begin
                    n_reg <= n_reg + 3'd1;
                end
                ST_O_D3:
                begin
                    j_reg <= (j_reg == 3'(OUTPUT_COUNT - 1)) ? 3'd0 : j_reg + 3'd1;
                    m_reg <= '0;
                end
                ST_H_RD:
                begin
                    if (mask_reg[j_reg])
                    begin
                        j_reg <= (j_reg == 3'(HIDDEN_COUNT - 1)) ? 3'd0 : j_reg + 3'd1;
                        u_reg <= '0;
                    end
                end
                ST_H_ACC:
                begin
                    m_reg <= (m_reg == 3'(OUTPUT_COUNT - 1)) ? 3'd0 : m_reg + 3'd1;
                end
                ST_H_D2:
                begin
                    j_reg <= (j_reg == 3'(HIDDEN_COUNT - 1)) ? 3'd0 : j_reg + 3'd1;
                    u_reg <= '0;
                end
                ST_U_RD, ST_U_WR:
                begin
                    if (state_reg == ST_U_WR || u_skip)
                    begin
                        u_reg <= u_reg + ADDR_W'(1);
                        if (u_reg == ADDR_W'(OFS_HB - 1) || u_reg == ADDR_W'(OFS_HO - 1)
                            || u_reg == ADDR_W'(OFS_OB - 1))
                        begin
                            j_reg <= '0;
                            m_reg <= '0;
                        end
                        else if (grp_ih)
                        begin
                            if (j_reg == 3'(HIDDEN_COUNT - 1))
                            begin
                                j_reg <= '0;
                                m_reg <= m_reg + 3'd1;
                            end
                            else
                            begin
                                j_reg <= j_reg + 3'd1;
                            end
                        end
                        else if (grp_hb)
                        begin
                            j_reg <= j_reg + 3'd1;
                        end
                        else if (grp_ho)
                        begin
                            if (m_reg == 3'(OUTPUT_COUNT - 1))
                            begin
                                m_reg <= '0;
                                j_reg <= j_reg + 3'd1;
                            end
                            else
                            begin
                                m_reg <= m_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            m_reg <= m_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (p_load)
        begin
            p_reg <= mul_a * mul_b;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_acc)
                begin
                    x_reg[0] <= sample.x_first;
                    x_reg[1] <= sample.x_second;
                    t_reg[0] <= (sample.target_first > 13'(ONE_Q12)) ? 13'(ONE_Q12)
                                : sample.target_first;
                    t_reg[1] <= (sample.target_second > 13'(ONE_Q12)) ? 13'(ONE_Q12)
                                : sample.target_second;
                    sq_reg   <= '0;
                end
            end
            ST_F_ACC:
            begin
                acc_reg <= ((m_reg == 3'd0) ? '0 : acc_reg) + ACC_W'(p_reg);
            end
            ST_F_ACT:
            begin
                if (is_hidden)
                begin
                    h_reg[n_reg] <= act;
                end
                else
                begin
                    y_reg[ko[0]] <= act;
                end
            end
            ST_O_D1:
            begin
                der_reg <= p_reg[22:12];
            end
            ST_O_D2:
            begin
                sq_reg <= sq_reg + p_reg[25:0];
            end
            ST_O_D3:
            begin
                d_reg[j_reg[0]] <= 12'((p_reg + MUL_P_W'(2048)) >>> 12);
            end
            ST_H_RD:
            begin
                if (mask_reg[j_reg])
                begin
                    hd_reg[j_reg] <= '0;
                end
            end
            ST_H_ACC:
            begin
                err_reg <= ((m_reg == 3'd0) ? '0 : err_reg) + 33'(p_reg);
            end
            ST_H_D2:
            begin
                hd_reg[j_reg] <= 18'((p_reg + MUL_P_W'(2048)) >>> 12);
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_y1_reg   <= load_reg ? '0 : y_reg[0];
                    out_y2_reg   <= load_reg ? '0 : y_reg[1];
                    out_loss_reg <= train_reg ? loss_val : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // A stalled result keeps the finished item parked at its end.
    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_valid_reg && !result.ready) |=> (state_reg == ST_FIN))
        else $error("finished item left before the output register freed");

    // Frozen hidden neurons never get a weight written by the update pass.
    a_frozen_untouched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_U_WR && u_reg < ADDR_W'(OFS_OB)) |-> !mask_reg[j_reg])
        else $error("weight of a frozen hidden neuron was updated");

    // The weight RAM is written only by a load or by the update pass.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_U_WR) || (sample_acc && load_reg == load_reg
                    && sample.kind == KIND_LOAD)))
        else $error("unexpected weight RAM write");
`endif

endmodule

### rtl/mbt_ram.sv
// ----------------------------------------------------------------------------
// mbt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbt_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 27
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds between reads.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
